@@ design/lifegen_pkg.sv @@
// ----------------------------------------------------------------------------
// lifegen_pkg: shared types and constants of the life generation engine
// Field widths, request and register codes, size limits and the Life rule
// counts used by the grid engine and its cell lanes.
// ----------------------------------------------------------------------------
package lifegen_pkg;

    // payload field widths
    localparam int FIELD_W   = 64;
    localparam int ROW_IDX_W = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // neighbour count width (0 to 8)
    localparam int CNT_W = 4;

    // request codes
    typedef enum logic [0:0] {
        REQ_WRITE_ROW = 1'b0,
        REQ_STEP      = 1'b1
    } t_req;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_USED  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_USED = 1'b1;

    // register reset values and smallest usable size
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 7'd40;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 7'd20;
    localparam logic [CFG_W-1:0] MIN_SIZE     = 7'd3;

    // Life rule
    localparam logic [CNT_W-1:0] SURVIVE_COUNT = 4'd2;
    localparam logic [CNT_W-1:0] BIRTH_COUNT   = 4'd3;

endpackage

@@ design/lifegen_cell.sv @@
// ----------------------------------------------------------------------------
// lifegen_cell: one cell lane of the generation engine
// Counts the eight neighbours of a cell and applies the survive and birth rule.
// ----------------------------------------------------------------------------
module lifegen_cell (
    input  logic       i_self,
    input  logic [7:0] i_nbrs,
    output logic       o_live
);
    import lifegen_pkg::*;

    logic [CNT_W-1:0] cnt;

    // neighbour population count
    always_comb begin
        cnt = '0;
        for (int k = 0; k < 8; k++) begin
            cnt = cnt + CNT_W'(i_nbrs[k]);
        end
    end

    // live cell survives on two or three, dead cell is born on three
    assign o_live = (cnt == BIRTH_COUNT) || (i_self && (cnt == SURVIVE_COUNT));

endmodule

@@ design/lifegen_row.sv @@
// ----------------------------------------------------------------------------
// lifegen_row: row of cell lanes with column wrap
// Feeds every column lane its wrapped 3x3 neighbourhood from the rows above,
// current and below, and merges the lane results into one masked row.
// ----------------------------------------------------------------------------
module lifegen_row #(
    parameter int COLS = 64
) (
    input  logic [COLS-1:0]                i_above,
    input  logic [COLS-1:0]                i_cur,
    input  logic [COLS-1:0]                i_below,
    input  logic [lifegen_pkg::CFG_W-1:0]  i_width,
    input  logic [COLS-1:0]                i_mask,
    output logic [COLS-1:0]                o_next
);
    import lifegen_pkg::*;

    localparam int CIW = (COLS > 1) ? $clog2(COLS) : 1;

    logic [CFG_W-1:0] wm1;
    logic [CIW-1:0]   wrap_col;
    logic             above_wrap;
    logic             cur_wrap;
    logic             below_wrap;
    logic [COLS-1:0]  lane_live;

    // last used column, source of the left neighbour of column zero
    assign wm1        = i_width - CFG_W'(1);
    assign wrap_col   = wm1[CIW-1:0];
    assign above_wrap = i_above[wrap_col];
    assign cur_wrap   = i_cur[wrap_col];
    assign below_wrap = i_below[wrap_col];

    // one lane per column
    for (genvar c = 0; c < COLS; c++) begin : g_lane
        logic       a_l, a_r, c_l, c_r, b_l, b_r;
        logic [7:0] nbrs;

        if (c == 0) begin : g_left_wrap
            assign a_l = above_wrap;
            assign c_l = cur_wrap;
            assign b_l = below_wrap;
        end else begin : g_left
            assign a_l = i_above[c-1];
            assign c_l = i_cur[c-1];
            assign b_l = i_below[c-1];
        end

        if (c == COLS-1) begin : g_right_edge
            assign a_r = i_above[0];
            assign c_r = i_cur[0];
            assign b_r = i_below[0];
        end else begin : g_right
            logic is_wrap;

            assign is_wrap = (wm1 == CFG_W'(c));
            assign a_r = is_wrap ? i_above[0] : i_above[c+1];
            assign c_r = is_wrap ? i_cur[0]   : i_cur[c+1];
            assign b_r = is_wrap ? i_below[0] : i_below[c+1];
        end

        assign nbrs = {a_l, i_above[c], a_r, c_l, c_r, b_l, i_below[c], b_r};

        lifegen_cell u_cell (
            .i_self (i_cur[c]),
            .i_nbrs (nbrs),
            .o_live (lane_live[c])
        );
    end

    // merge lanes, clear unused columns
    assign o_next = lane_live & i_mask;

endmodule

@@ design/lifegen_grid.sv @@
// ----------------------------------------------------------------------------
// lifegen_grid: cell grid storage
// One row per word, one write and one registered read per cycle. A row that
// was never written since reset reads as all dead through its valid bit.
// ----------------------------------------------------------------------------
module lifegen_grid #(
    parameter int COLS = 64,
    parameter int ROWS = 64,
    parameter int AW   = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  logic [COLS-1:0] i_wr_data,
    input  logic [AW-1:0]   i_rd_addr,
    output logic [COLS-1:0] o_rd_data
);
    logic [COLS-1:0] mem [ROWS];
    logic [ROWS-1:0] r_row_vld;
    logic [COLS-1:0] r_rd_data;
    logic            r_rd_vld;

    // row storage
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    // row valid bits, all rows dead after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_row_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

@@ design/life_automaton_generation_top.sv @@
// ----------------------------------------------------------------------------
// life_automaton_generation_top: toroidal Life grid generation engine
// Holds the cell grid, stores written rows and advances the used grid one
// generation per step beat, emitting every new row in order.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   in      | input     | i_in_valid / o_in_stall | i_req_type i_row_index
//           |           |                         | i_row_cells
//   out     | output    | o_out_valid/i_out_stall | o_out_row_index o_out_row_cells
//           |           |                         | o_last_row
//   cfg     | input     | i_cfg_wr_en             | i_cfg_index i_cfg_data
//
// A step makes two grid reads to fetch the last and first rows, then produces
// one row per cycle while the output is not stalled, through the single read
// port of the grid memory, one lane per column. An output stall holds the row
// sequencer in place; input is stalled while a step runs. Reset (synchronous)
// clears the row valid bits, so the grid reads all dead at once, with no
// clearing pass.
// ----------------------------------------------------------------------------
module life_automaton_generation_top #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input beats
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_req_type,
    input  logic [lifegen_pkg::ROW_IDX_W-1:0]     i_row_index,
    input  logic [lifegen_pkg::FIELD_W-1:0]       i_row_cells,
    // output beats
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [lifegen_pkg::ROW_IDX_W-1:0]     o_out_row_index,
    output logic [lifegen_pkg::FIELD_W-1:0]       o_out_row_cells,
    output logic                                  o_last_row,
    // configuration writes
    input  logic                                  i_cfg_wr_en,
    input  logic [lifegen_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lifegen_pkg::CFG_W-1:0]         i_cfg_data
);
    import lifegen_pkg::*;

    localparam int COLS = MAX_COLUMNS;
    localparam int AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    localparam logic [CFG_W-1:0] MAX_COLS_C = CFG_W'(MAX_COLUMNS);
    localparam logic [CFG_W-1:0] MAX_ROWS_C = CFG_W'(MAX_ROWS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD_PREV,
        S_LOAD_FIRST,
        S_ROW
    } t_state;

    // configuration registers
    logic [CFG_W-1:0] r_width_used;
    logic [CFG_W-1:0] r_height_used;

    // sequencer and output registers
    t_state              r_state,         n_state;
    logic [AW-1:0]       r_row,           n_row;
    logic [COLS-1:0]     r_prev,          n_prev;
    logic [COLS-1:0]     r_cur,           n_cur;
    logic [COLS-1:0]     r_first,         n_first;
    logic                r_out_valid,     n_out_valid;
    logic [ROW_IDX_W-1:0] r_out_idx,      n_out_idx;
    logic [COLS-1:0]     r_out_cells,     n_out_cells;
    logic                r_out_last,      n_out_last;

    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;
    logic [CFG_W-1:0] hm1;
    logic [CFG_W-1:0] row_p2;
    logic [COLS-1:0]  col_mask;
    logic [COLS-1:0]  rd_data;
    logic [COLS-1:0]  rd_masked;
    logic [COLS-1:0]  below;
    logic [COLS-1:0]  next_row;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [COLS-1:0]  wr_data;
    logic             in_fire;
    logic             out_free;
    logic             is_last;
    logic             advance;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_used  <= WIDTH_RESET;
            r_height_used <= HEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WIDTH_USED:  r_width_used  <= i_cfg_data;
                CFG_HEIGHT_USED: r_height_used <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // effective size, clamped between the smallest usable size and the storage
    always_comb begin
        if (r_width_used < MIN_SIZE) begin
            w_eff = MIN_SIZE;
        end else if (r_width_used > MAX_COLS_C) begin
            w_eff = MAX_COLS_C;
        end else begin
            w_eff = r_width_used;
        end
        if (r_height_used < MIN_SIZE) begin
            h_eff = MIN_SIZE;
        end else if (r_height_used > MAX_ROWS_C) begin
            h_eff = MAX_ROWS_C;
        end else begin
            h_eff = r_height_used;
        end
    end

    assign hm1 = h_eff - CFG_W'(1);

    // used column mask
    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            col_mask[c] = (CFG_W'(c) < w_eff);
        end
    end

    // handshake conditions
    assign in_fire   = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign is_last   = (CFG_W'(r_row) == hm1);
    assign advance   = (r_state == S_ROW) && out_free;
    assign rd_masked = rd_data & col_mask;
    assign below     = is_last ? r_first : rd_masked;
    assign row_p2    = CFG_W'(r_row) + CFG_W'(2);

    // grid read address: last row, first row, then one row ahead
    always_comb begin
        rd_addr = '0;
        case (r_state)
            S_IDLE:       rd_addr = AW'(hm1);
            S_LOAD_PREV:  rd_addr = '0;
            S_LOAD_FIRST: rd_addr = AW'(1);
            S_ROW: begin
                if (!advance) begin
                    rd_addr = AW'(CFG_W'(r_row) + CFG_W'(1));
                end else if (row_p2 < h_eff) begin
                    rd_addr = AW'(row_p2);
                end
            end
            default:      rd_addr = '0;
        endcase
    end

    // grid write: new generation row or a written input row
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_row;
        wr_data = next_row;
        if (advance) begin
            wr_en = 1'b1;
        end else if (in_fire && (i_req_type == REQ_WRITE_ROW)
                     && (CFG_W'(i_row_index) < MAX_ROWS_C)) begin
            wr_en   = 1'b1;
            wr_addr = AW'(i_row_index);
            wr_data = i_row_cells[COLS-1:0] & col_mask;
        end
    end

    lifegen_grid #(
        .COLS (COLS),
        .ROWS (MAX_ROWS),
        .AW   (AW)
    ) u_grid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lifegen_row #(
        .COLS (COLS)
    ) u_row (
        .i_above (r_prev),
        .i_cur   (r_cur),
        .i_below (below),
        .i_width (w_eff),
        .i_mask  (col_mask),
        .o_next  (next_row)
    );

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_first     = r_first;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_idx   = r_out_idx;
        n_out_cells = r_out_cells;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (in_fire && (i_req_type == REQ_STEP)) begin
                    n_state = S_LOAD_PREV;
                end
            end
            S_LOAD_PREV: begin
                n_prev  = rd_masked;
                n_state = S_LOAD_FIRST;
            end
            S_LOAD_FIRST: begin
                n_first = rd_masked;
                n_cur   = rd_masked;
                n_row   = '0;
                n_state = S_ROW;
            end
            S_ROW: begin
                if (advance) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = ROW_IDX_W'(r_row);
                    n_out_cells = next_row;
                    n_out_last  = is_last;
                    n_prev      = r_cur;
                    n_cur       = below;
                    n_row       = r_row + AW'(1);
                    if (is_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer state and output beat registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_row       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_row       <= n_row;
        end
        r_prev      <= n_prev;
        r_cur       <= n_cur;
        r_first     <= n_first;
        r_out_idx   <= n_out_idx;
        r_out_cells <= n_out_cells;
        r_out_last  <= n_out_last;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_out_row_index = r_out_idx;
    assign o_out_row_cells = FIELD_W'(r_out_cells);
    assign o_last_row      = r_out_last;

    // last row beat carries the final used row index
    a_last_row_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (CFG_W'(r_out_idx) == hm1))
        else $error("last row flag on wrong row index");

    // emitted rows never carry cells outside the used width
    a_unused_cols_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_cells & ~col_mask) == '0))
        else $error("output row has cells beyond used width");

    // a step beat reaches the row phase after the two priming reads
    a_step_priming: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_req_type == REQ_STEP)) |-> ##3 (r_state == S_ROW))
        else $error("step did not reach row phase");

    // row counter stays inside the used height
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW) |-> (CFG_W'(r_row) < h_eff))
        else $error("row counter beyond used height");

endmodule
